>>> hw/rtl/lqet_pkg.sv
// ----------------------------------------------------------------------------
// Link quality tracker package
// Shared types, register indexes and arithmetic constants.
// ----------------------------------------------------------------------------
package lqet_pkg;

  localparam int LINK_SLOTS  = 8;
  localparam int SLOT_W      = 3;
  localparam int NUM_METRICS = 4;

  // Metric lanes, also the bit order of the per-slot valid vector.
  localparam int MET_COST  = 0;
  localparam int MET_RTT   = 1;
  localparam int MET_FAIL  = 2;
  localparam int MET_QUEUE = 3;

  localparam int WIDE_W  = 16;
  localparam int MILLE_W = 10;
  localparam int ALPHA_W = 7;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARKER    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd3;

  localparam logic [ALPHA_W-1:0] ALPHA_RST     = 7'd25;
  localparam logic [MILLE_W-1:0] THRESHOLD_RST = 10'd800;
  localparam logic [WIDE_W-1:0]  MARKER_RST    = 16'hFFFF;
  localparam logic [MILLE_W-1:0] LIMIT_RST     = 10'd1000;

  // Request commands.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Blend arithmetic: sum = old*(100-a) + new*a + 50 stays below 2^23, and
  // floor(sum/100) = (sum * RECIP_MUL) >> RECIP_SHIFT is exact over that range.
  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 7'd100;
  localparam int SUM_W       = 23;
  localparam int RECIP_W     = 24;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 30;
  localparam logic [SUM_W-1:0]   ROUND_BIAS = 23'd50;
  localparam logic [RECIP_W-1:0] RECIP_MUL  = 24'd10737419;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [MILLE_W-1:0] threshold;
    logic [WIDE_W-1:0]  marker;
    logic [MILLE_W-1:0] limit;
  } cfg_t;

  // One classified request as it waits in the queue.
  typedef struct packed {
    logic                   in_range;
    logic [SLOT_W-1:0]      slot;
    logic                   up;
    logic [NUM_METRICS-1:0] ok;
    logic [WIDE_W-1:0]      cost;
    logic [WIDE_W-1:0]      rtt;
    logic [MILLE_W-1:0]     fail;
    logic [MILLE_W-1:0]     queue;
  } op_t;

endpackage

>>> hw/rtl/lqet_front.sv
// ----------------------------------------------------------------------------
// Link quality tracker front end
// Accepts requests and reduces each to a slot, an up flag and per-metric
// sample validity.
// ----------------------------------------------------------------------------
module lqet_front (
  input  lqet_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_command,
  input  logic [2:0]                 in_link_slot,
  input  logic                       in_link_up,
  input  logic                       in_metrics_ok,
  input  logic                       in_cost_present,
  input  logic [15:0]                in_cost_sample,
  input  logic                       in_rtt_present,
  input  logic [15:0]                in_rtt_sample,
  input  logic                       in_fail_present,
  input  logic [15:0]                in_fail_sample,
  input  logic                       in_queue_present,
  input  logic [15:0]                in_queue_sample,
  input  logic                       q_ready,
  output logic                       q_push,
  output lqet_pkg::op_t              q_op
);
  import lqet_pkg::*;

  logic live;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  always_comb begin
    q_op          = '0;
    q_op.in_range = ({1'b0, in_link_slot} < (SLOT_W + 1)'(LINK_SLOTS));
    q_op.slot     = in_link_slot;
    // A clear or an out-of-range slot carries no valid metric and no up flag,
    // which makes the back end produce an all-zero record.
    live          = q_op.in_range & (in_command == CMD_SAMPLE);
    q_op.up       = live & in_link_up;
    q_op.ok[MET_COST]  = live & in_metrics_ok & in_cost_present &
                         (in_cost_sample != '0) & (in_cost_sample != cfg.marker);
    q_op.ok[MET_RTT]   = live & in_metrics_ok & in_rtt_present;
    q_op.ok[MET_FAIL]  = live & in_metrics_ok & in_fail_present &
                         (in_fail_sample <= WIDE_W'(cfg.limit));
    q_op.ok[MET_QUEUE] = live & in_metrics_ok & in_queue_present &
                         (in_queue_sample <= WIDE_W'(cfg.limit));
    q_op.cost  = in_cost_sample;
    q_op.rtt   = in_rtt_sample;
    // Valid per-mille samples never exceed the 10-bit limit.
    q_op.fail  = in_fail_sample[MILLE_W-1:0];
    q_op.queue = in_queue_sample[MILLE_W-1:0];
  end

endmodule

>>> hw/rtl/lqet_fifo.sv
// ----------------------------------------------------------------------------
// Link quality tracker request queue
// Short first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module lqet_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lqet_pkg::op_t push_op,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output lqet_pkg::op_t head_op
);
  import lqet_pkg::*;

  op_t                   mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign not_full  = (count_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_op   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hw/rtl/lqet_back.sv
// ----------------------------------------------------------------------------
// Link quality tracker back end
// Reads the slot record, blends each metric in two stages, writes the record
// back and holds the result in an output register.
// ----------------------------------------------------------------------------
module lqet_back (
  input  logic           clk,
  input  logic           rst_n,
  input  lqet_pkg::cfg_t cfg,
  input  logic           head_valid,
  input  lqet_pkg::op_t  head_op,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_up_out,
  output logic           out_cost_ok,
  output logic [15:0]    out_cost_avg,
  output logic           out_rtt_ok,
  output logic [15:0]    out_rtt_avg,
  output logic           out_fail_ok,
  output logic [9:0]     out_fail_avg,
  output logic           out_queue_ok,
  output logic [9:0]     out_queue_avg,
  output logic           out_pressure_high
);
  import lqet_pkg::*;

  // Slot record.
  logic                   up_r    [LINK_SLOTS];
  logic [NUM_METRICS-1:0] valid_r [LINK_SLOTS];
  logic [WIDE_W-1:0]      cost_mem_r  [LINK_SLOTS];
  logic [WIDE_W-1:0]      rtt_mem_r   [LINK_SLOTS];
  logic [MILLE_W-1:0]     fail_mem_r  [LINK_SLOTS];
  logic [MILLE_W-1:0]     queue_mem_r [LINK_SLOTS];

  // Blend stage.
  logic                   s1_vld_r, s1_vld_nxt;
  logic                   s1_write_r;
  logic [SLOT_W-1:0]      s1_slot_r;
  logic                   s1_up_r;
  logic [NUM_METRICS-1:0] s1_ok_r;
  logic [SUM_W-1:0]       s1_sum_r [NUM_METRICS];

  logic                   out_vld_r, out_vld_nxt;

  logic                   s1_adv, hazard;
  logic [ALPHA_W-1:0]     alpha_sat;
  logic [NUM_METRICS-1:0] was_valid;
  logic [WIDE_W-1:0]      prior [NUM_METRICS];
  logic [WIDE_W-1:0]      fresh [NUM_METRICS];
  logic [ALPHA_W-1:0]     w_old [NUM_METRICS];
  logic [ALPHA_W-1:0]     w_new [NUM_METRICS];
  logic [SUM_W-1:0]       sum   [NUM_METRICS];
  logic [PROD_W-1:0]      prod  [NUM_METRICS];
  logic [WIDE_W-1:0]      quot  [NUM_METRICS];
  logic                   press;

  assign s1_adv = s1_vld_r & (~out_vld_r | out_ready);
  // The record of a slot still in the blend stage is not yet written back,
  // so a request for the same slot waits until that write is done.
  assign hazard = s1_vld_r & s1_write_r & head_op.in_range & (head_op.slot == s1_slot_r);
  assign pop    = head_valid & (~s1_vld_r | s1_adv) & ~hazard;

  assign alpha_sat = (cfg.alpha > ALPHA_FULL) ? ALPHA_FULL : cfg.alpha;

  always_comb begin
    was_valid         = valid_r[head_op.slot];
    prior[MET_COST]   = cost_mem_r[head_op.slot];
    prior[MET_RTT]    = rtt_mem_r[head_op.slot];
    prior[MET_FAIL]   = WIDE_W'(fail_mem_r[head_op.slot]);
    prior[MET_QUEUE]  = WIDE_W'(queue_mem_r[head_op.slot]);
    fresh[MET_COST]   = head_op.cost;
    fresh[MET_RTT]    = head_op.rtt;
    fresh[MET_FAIL]   = WIDE_W'(head_op.fail);
    fresh[MET_QUEUE]  = WIDE_W'(head_op.queue);
    for (int i = 0; i < NUM_METRICS; i++) begin
      // An invalid sample weighs nothing and rounds to zero; a first sample
      // takes full weight, which reproduces it exactly.
      if (!head_op.ok[i]) begin
        w_old[i] = '0;
        w_new[i] = '0;
      end else if (!was_valid[i]) begin
        w_old[i] = '0;
        w_new[i] = ALPHA_FULL;
      end else begin
        w_old[i] = ALPHA_FULL - alpha_sat;
        w_new[i] = alpha_sat;
      end
      sum[i] = SUM_W'(prior[i]) * SUM_W'(w_old[i]) + SUM_W'(fresh[i]) * SUM_W'(w_new[i])
             + ROUND_BIAS;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_METRICS; i++) begin
      prod[i] = PROD_W'(s1_sum_r[i]) * PROD_W'(RECIP_MUL);
      quot[i] = prod[i][RECIP_SHIFT +: WIDE_W];
    end
    press = s1_up_r & s1_ok_r[MET_QUEUE] & (quot[MET_QUEUE][MILLE_W-1:0] >= cfg.threshold);
  end

  always_comb begin
    s1_vld_nxt = pop ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_r);
    out_vld_nxt = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_write_r <= head_op.in_range;
      s1_slot_r  <= head_op.slot;
      s1_up_r    <= head_op.up;
      s1_ok_r    <= head_op.ok;
      s1_sum_r   <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LINK_SLOTS; s++) begin
        cost_mem_r[s]  <= '0;
        rtt_mem_r[s]   <= '0;
        fail_mem_r[s]  <= '0;
        queue_mem_r[s] <= '0;
      end
    end else if (s1_adv && s1_write_r) begin
      cost_mem_r[s1_slot_r]  <= quot[MET_COST];
      rtt_mem_r[s1_slot_r]   <= quot[MET_RTT];
      fail_mem_r[s1_slot_r]  <= quot[MET_FAIL][MILLE_W-1:0];
      queue_mem_r[s1_slot_r] <= quot[MET_QUEUE][MILLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LINK_SLOTS; s++) begin
        up_r[s]    <= 1'b0;
        valid_r[s] <= '0;
      end
    end else if (s1_adv && s1_write_r) begin
      up_r[s1_slot_r]    <= s1_up_r;
      valid_r[s1_slot_r] <= s1_ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_up_out        <= s1_up_r;
      out_cost_ok       <= s1_ok_r[MET_COST];
      out_cost_avg      <= quot[MET_COST];
      out_rtt_ok        <= s1_ok_r[MET_RTT];
      out_rtt_avg       <= quot[MET_RTT];
      out_fail_ok       <= s1_ok_r[MET_FAIL];
      out_fail_avg      <= quot[MET_FAIL][MILLE_W-1:0];
      out_queue_ok      <= s1_ok_r[MET_QUEUE];
      out_queue_avg     <= quot[MET_QUEUE][MILLE_W-1:0];
      out_pressure_high <= press;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;

endmodule

>>> hw/rtl/link_quality_ewma_tracker.sv
// ----------------------------------------------------------------------------
// Link quality tracker
// Per-slot up flag and percent-weighted moving averages of route cost,
// round-trip time, transmit failure and queue pressure.
// ----------------------------------------------------------------------------
// Each request updates one of eight slot records and returns the updated
// record one-for-one, in order. The block takes one request per cycle while
// its queue has room; a request for the same slot as the one just before it
// waits for that write-back, because the slot record is read, blended in a
// multiply stage, then scaled by a reciprocal multiply and written back, and
// the next read of that slot must see the write. Results leave through an
// output register, and a four-entry request queue lets requests keep
// arriving while a result waits. Configuration is written through cfg_we,
// cfg_index and cfg_wdata, by the user only while no request is in flight;
// the block does not enforce it, and has no state-clearing pass after reset.
module link_quality_ewma_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [2:0]  in_link_slot,
  input  logic        in_link_up,
  input  logic        in_metrics_ok,
  input  logic        in_cost_present,
  input  logic [15:0] in_cost_sample,
  input  logic        in_rtt_present,
  input  logic [15:0] in_rtt_sample,
  input  logic        in_fail_present,
  input  logic [15:0] in_fail_sample,
  input  logic        in_queue_present,
  input  logic [15:0] in_queue_sample,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_up_out,
  output logic        out_cost_ok,
  output logic [15:0] out_cost_avg,
  output logic        out_rtt_ok,
  output logic [15:0] out_rtt_avg,
  output logic        out_fail_ok,
  output logic [9:0]  out_fail_avg,
  output logic        out_queue_ok,
  output logic [9:0]  out_queue_avg,
  output logic        out_pressure_high
);
  import lqet_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  op_t  push_op, head_op;
  logic q_push, q_not_full, q_not_empty, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA:     cfg_nxt.alpha     = cfg_wdata[ALPHA_W-1:0];
        CFG_THRESHOLD: cfg_nxt.threshold = cfg_wdata[MILLE_W-1:0];
        CFG_MARKER:    cfg_nxt.marker    = cfg_wdata;
        CFG_LIMIT:     cfg_nxt.limit     = cfg_wdata[MILLE_W-1:0];
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alpha     <= ALPHA_RST;
      cfg_r.threshold <= THRESHOLD_RST;
      cfg_r.marker    <= MARKER_RST;
      cfg_r.limit     <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lqet_front u_front (
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_link_slot     (in_link_slot),
    .in_link_up       (in_link_up),
    .in_metrics_ok    (in_metrics_ok),
    .in_cost_present  (in_cost_present),
    .in_cost_sample   (in_cost_sample),
    .in_rtt_present   (in_rtt_present),
    .in_rtt_sample    (in_rtt_sample),
    .in_fail_present  (in_fail_present),
    .in_fail_sample   (in_fail_sample),
    .in_queue_present (in_queue_present),
    .in_queue_sample  (in_queue_sample),
    .q_ready          (q_not_full),
    .q_push           (q_push),
    .q_op             (push_op)
  );

  lqet_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_op   (push_op),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  lqet_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head_valid        (q_not_empty),
    .head_op           (head_op),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_up_out        (out_up_out),
    .out_cost_ok       (out_cost_ok),
    .out_cost_avg      (out_cost_avg),
    .out_rtt_ok        (out_rtt_ok),
    .out_rtt_avg       (out_rtt_avg),
    .out_fail_ok       (out_fail_ok),
    .out_fail_avg      (out_fail_avg),
    .out_queue_ok      (out_queue_ok),
    .out_queue_avg     (out_queue_avg),
    .out_pressure_high (out_pressure_high)
  );

endmodule
